@@ sv/u8lt_pkg.sv @@
package u8lt_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int OUT_POS_W = 32;
    localparam int LINE_W    = 32;
    localparam int POS_BITS_DEF = 32;

    // lead byte thresholds
    localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;

    localparam logic [BYTE_W-1:0] MASK_2B   = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_3B   = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_4B   = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_CONT = 8'h3F;

    localparam logic [CP_W-1:0] CH_LF = 21'h0A;
    localparam logic [CP_W-1:0] CH_CR = 21'h0D;

    typedef logic [1:0] cont_cnt_t;

endpackage

@@ sv/utf8_decode_line_tracker.sv @@
// An accepted byte is held in the byte register; a code point it completes is then
// held in the result register, and an output stall can hold the byte back.
// One byte per cycle unless the output stalls; one code point per 1 to 4 bytes.
// The registers advance together over the combinational decode and counter update.
// Reset (rst_n low, async) empties both registers and clears the partial code point,
// the pending continuation count, the CR flag and the character and line counters.
module utf8_decode_line_tracker #(
    parameter int POS_BITS = u8lt_pkg::POS_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [u8lt_pkg::BYTE_W-1:0]       in_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [u8lt_pkg::CP_W-1:0]         code_point,
    output logic [u8lt_pkg::OUT_POS_W-1:0]    char_pos,
    output logic                              line_mark,
    output logic [u8lt_pkg::OUT_POS_W-1:0]    line_start,
    output logic [u8lt_pkg::LINE_W-1:0]       line_number
);

    // input stage
    logic                             s1_valid_reg;
    logic [u8lt_pkg::BYTE_W-1:0]      s1_byte_reg;
    logic                             s1_fire;

    // decoder state
    logic [u8lt_pkg::CP_W-1:0]        accum_reg, accum_next;
    u8lt_pkg::cont_cnt_t              bytes_left_reg, bytes_left_next;
    logic                             cr_seen_reg, cr_seen_next;
    logic [POS_BITS-1:0]              char_count_reg, char_count_next;
    logic [u8lt_pkg::LINE_W-1:0]      line_count_reg, line_count_next;

    // result stage
    logic                             out_valid_reg, out_valid_next;
    logic [u8lt_pkg::CP_W-1:0]        code_point_reg;
    logic [u8lt_pkg::OUT_POS_W-1:0]   char_pos_reg;
    logic                             line_mark_reg;
    logic [u8lt_pkg::OUT_POS_W-1:0]   line_start_reg;
    logic [u8lt_pkg::LINE_W-1:0]      line_number_reg;

    // decode results
    logic                             emit;
    logic [u8lt_pkg::CP_W-1:0]        cp;
    logic [u8lt_pkg::CP_W-1:0]        acc_shift;
    logic [POS_BITS-1:0]              pos_inc;
    logic                             is_lf;
    logic                             mark;
    logic [POS_BITS-1:0]              lstart_full;
    logic [u8lt_pkg::OUT_POS_W-1:0]   pos_out;
    logic [u8lt_pkg::OUT_POS_W-1:0]   lstart_out;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign acc_shift = {accum_reg[u8lt_pkg::CP_W-7:0], s1_byte_reg[5:0]};

    always_comb
    begin
        accum_next      = accum_reg;
        bytes_left_next = bytes_left_reg;
        emit            = 1'b0;
        cp              = '0;
        if (bytes_left_reg != 2'd0)
        begin
            accum_next      = acc_shift;
            bytes_left_next = bytes_left_reg - 2'd1;
            if (bytes_left_reg == 2'd1)
            begin
                emit       = 1'b1;
                cp         = acc_shift;
                accum_next = '0;
            end
        end
        else if (s1_byte_reg < u8lt_pkg::LEAD_2B)
        begin
            emit       = 1'b1;
            cp         = {{(u8lt_pkg::CP_W-u8lt_pkg::BYTE_W){1'b0}}, s1_byte_reg};
            accum_next = '0;
        end
        else if (s1_byte_reg < u8lt_pkg::LEAD_3B)
        begin
            accum_next      = {{(u8lt_pkg::CP_W-u8lt_pkg::BYTE_W){1'b0}},
                               s1_byte_reg & u8lt_pkg::MASK_2B};
            bytes_left_next = 2'd1;
        end
        else if (s1_byte_reg < u8lt_pkg::LEAD_4B)
        begin
            accum_next      = {{(u8lt_pkg::CP_W-u8lt_pkg::BYTE_W){1'b0}},
                               s1_byte_reg & u8lt_pkg::MASK_3B};
            bytes_left_next = 2'd2;
        end
        else
        begin
            accum_next      = {{(u8lt_pkg::CP_W-u8lt_pkg::BYTE_W){1'b0}},
                               s1_byte_reg & u8lt_pkg::MASK_4B};
            bytes_left_next = 2'd3;
        end
    end

    // saturating position increment
    assign pos_inc = (&char_count_reg) ? char_count_reg : char_count_reg + 1'b1;

    assign is_lf       = (cp == u8lt_pkg::CH_LF);
    assign mark        = emit && (is_lf || cr_seen_reg);
    assign lstart_full = is_lf ? pos_inc : char_count_reg;

    generate
        if (POS_BITS >= u8lt_pkg::OUT_POS_W)
        begin : g_pos_trunc
            assign pos_out    = char_count_reg[u8lt_pkg::OUT_POS_W-1:0];
            assign lstart_out = lstart_full[u8lt_pkg::OUT_POS_W-1:0];
        end
        else
        begin : g_pos_ext
            assign pos_out    = {{(u8lt_pkg::OUT_POS_W-POS_BITS){1'b0}}, char_count_reg};
            assign lstart_out = {{(u8lt_pkg::OUT_POS_W-POS_BITS){1'b0}}, lstart_full};
        end
    endgenerate

    always_comb
    begin
        cr_seen_next    = cr_seen_reg;
        char_count_next = char_count_reg;
        line_count_next = line_count_reg;
        if (emit)
        begin
            // CR followed by LF: the LF records the line, so the flag just drops
            cr_seen_next    = !is_lf && (cp == u8lt_pkg::CH_CR);
            char_count_next = pos_inc;
            if (mark && !(&line_count_reg))
            begin
                line_count_next = line_count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (s1_fire)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            accum_reg      <= '0;
            bytes_left_reg <= '0;
            cr_seen_reg    <= 1'b0;
            char_count_reg <= '0;
            line_count_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                accum_reg      <= accum_next;
                bytes_left_reg <= bytes_left_next;
                cr_seen_reg    <= cr_seen_next;
                char_count_reg <= char_count_next;
                line_count_reg <= line_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s1_fire && emit)
        begin
            code_point_reg  <= cp;
            char_pos_reg    <= pos_out;
            line_mark_reg   <= mark;
            line_start_reg  <= mark ? lstart_out : '0;
            line_number_reg <= mark ? line_count_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = code_point_reg;
    assign char_pos    = char_pos_reg;
    assign line_mark   = line_mark_reg;
    assign line_start  = line_start_reg;
    assign line_number = line_number_reg;

    a_no_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !line_mark_reg |-> line_start_reg == '0 && line_number_reg == '0)
        else $error("line fields nonzero without a line mark");

    a_cr_start_here: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && line_mark_reg && code_point_reg != u8lt_pkg::CH_LF
        |-> line_start_reg == char_pos_reg)
        else $error("line after CR must start at the character itself");

    a_line_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> line_count_reg >= $past(line_count_reg))
        else $error("line count went backward");

    a_char_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> char_count_reg >= $past(char_count_reg))
        else $error("character count went backward");

    a_cont_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && bytes_left_reg != 2'd0 |=> bytes_left_reg == $past(bytes_left_reg) - 2'd1)
        else $error("continuation count did not step down");

endmodule
